@@ rtl/fbs_pkg.sv @@
// shared types, constants and helpers for the frame byte statistics block
package fbs_pkg;

   localparam int unsigned DimWidth      = 14;
   localparam int unsigned SizeWidth     = 27;
   localparam int unsigned AreaWidth     = 2 * DimWidth;
   localparam int unsigned SumWidth      = 35;
   localparam int unsigned DividendWidth = SumWidth + 7;
   localparam int unsigned MeanWidth     = 15;
   localparam int unsigned DivCountWidth = $clog2(DividendWidth);
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [31:0] FnvBasis = 32'd2166136261;
   localparam logic [31:0] FnvPrime = 32'd16777619;
   localparam logic [7:0]  MinReset = 8'hff;

   // register indexes of the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_BYTES  = 2'd2;

   // status codes of a result word
   localparam logic STATUS_OK           = 1'b0;
   localparam logic STATUS_BAD_GEOMETRY = 1'b1;

   typedef struct packed {
      logic [31:0]          hash;
      logic [7:0]           min_byte;
      logic [7:0]           max_byte;
      logic [SizeWidth-1:0] nonzero;
      logic [SumWidth-1:0]  luma_sum;
      logic [SumWidth-1:0]  chroma_sum;
      logic [SizeWidth-1:0] byte_index;
   } fbs_stats_type;

   // sum * 100 as shifts and adds: 64 + 32 + 4
   function automatic logic [DividendWidth-1:0] times_100(input logic [SumWidth-1:0] sum);
      logic [DividendWidth-1:0] wide;
      wide = DividendWidth'(sum);
      return (wide << 6) + (wide << 5) + (wide << 2);
   endfunction

endpackage

@@ rtl/frame_byte_statistics.sv @@
// top level: csr registers, frame sequencer and result register for frame byte statistics
//
// Bytes of one planar frame enter on req_ (valid/ready), luma first, then chroma.
// frame_width, frame_height and frame_bytes are written on csr_; the user must
// write them only while idle, as the block does not enforce it; any write to one
// of them restarts the frame, a write to an unused index is ignored. A byte that
// does not end the frame gives no word on rsp_. The byte that ends the frame gives
// one word with the hash, min, max, nonzero count and both means x100; the two
// means come from one shared restoring divider, one after the other, and req_ready
// stays low until that word is written to the result register.
// With invalid geometry (frame_bytes zero, or width*height not below frame_bytes)
// every byte gives one word with status 1 and all other fields zero.
// The result sits in an output register: while rsp_ready is low, mid-frame bytes
// are still taken, but a byte that would produce a word waits until it is free.
// Reset clears the csr registers to zero and all accumulators to their start values.
module frame_byte_statistics
   import fbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_pixel_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_status,
   output logic [31:0]              rsp_frame_hash,
   output logic [7:0]               rsp_min_byte,
   output logic [7:0]               rsp_max_byte,
   output logic [SizeWidth-1:0]     rsp_nonzero_count,
   output logic [MeanWidth-1:0]     rsp_luma_mean_x100,
   output logic [MeanWidth-1:0]     rsp_chroma_mean_x100,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [SizeWidth-1:0]     csr_write_data
);

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_START_LUMA,
      ST_WAIT_LUMA,
      ST_START_CHROMA,
      ST_WAIT_CHROMA
   } state_type;

   state_type            state_ff, state_in;
   logic [DimWidth-1:0]  width_ff, width_in;
   logic [DimWidth-1:0]  height_ff, height_in;
   logic [SizeWidth-1:0] total_ff, total_in;
   logic [MeanWidth-1:0] luma_mean_ff, luma_mean_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 status_ff, status_in;
   logic [31:0]          hash_ff, hash_in;
   logic [7:0]           min_ff, min_in;
   logic [7:0]           max_ff, max_in;
   logic [SizeWidth-1:0] nonzero_ff, nonzero_in;
   logic [MeanWidth-1:0] rsp_luma_ff, rsp_luma_in;
   logic [MeanWidth-1:0] rsp_chroma_ff, rsp_chroma_in;

   fbs_stats_type          stats;
   logic [AreaWidth-1:0]   luma_area;
   logic [AreaWidth-1:0]   chroma_area;
   logic                   geometry_bad;
   logic [SizeWidth-1:0]   next_index;
   logic                   last_byte;
   logic                   out_free;
   logic                   req_fire;
   logic                   step;
   logic                   cfg_clear;
   logic                   frame_clear;
   logic                   div_start;
   logic [DividendWidth-1:0] div_dividend;
   logic [AreaWidth-1:0]   div_divisor;
   logic                   div_busy;
   logic                   div_done;
   logic [MeanWidth-1:0]   div_quotient;

   assign luma_area    = AreaWidth'(width_ff) * AreaWidth'(height_ff);
   assign geometry_bad = (total_ff == '0) || (luma_area >= AreaWidth'(total_ff));
   assign chroma_area  = AreaWidth'(total_ff) - luma_area;
   assign next_index   = stats.byte_index + 1'b1;
   assign last_byte    = next_index == total_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // mid-frame bytes need no result slot
   assign req_ready = (state_ff == ST_ACCEPT) && (out_free || (!geometry_bad && !last_byte));
   assign req_fire  = req_valid && req_ready;
   assign step      = req_fire && !geometry_bad;

   assign cfg_clear = csr_write_enable &&
                      (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT ||
                       csr_index == CSR_FRAME_BYTES);
   assign frame_clear = cfg_clear || (state_ff == ST_WAIT_CHROMA && div_done);

   assign div_start    = (state_ff == ST_START_LUMA) || (state_ff == ST_START_CHROMA);
   assign div_dividend = (state_ff == ST_START_LUMA) ? times_100(stats.luma_sum)
                                                     : times_100(stats.chroma_sum);
   assign div_divisor  = (state_ff == ST_START_LUMA) ? luma_area : chroma_area;

   fbs_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .clear      (frame_clear),
      .step       (step),
      .pixel_byte (req_pixel_byte),
      .luma_area  (luma_area),
      .stats      (stats)
   );

   fbs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      total_in  = total_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_write_data[DimWidth-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_write_data[DimWidth-1:0];
            CSR_FRAME_BYTES:  total_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         total_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      luma_mean_in  = luma_mean_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      hash_in       = hash_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      nonzero_in    = nonzero_ff;
      rsp_luma_in   = rsp_luma_ff;
      rsp_chroma_in = rsp_chroma_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (req_fire && geometry_bad) begin
               rsp_valid_in  = 1'b1;
               status_in     = STATUS_BAD_GEOMETRY;
               hash_in       = '0;
               min_in        = '0;
               max_in        = '0;
               nonzero_in    = '0;
               rsp_luma_in   = '0;
               rsp_chroma_in = '0;
            end else if (step && last_byte) begin
               state_in = ST_START_LUMA;
            end
         end
         ST_START_LUMA: begin
            state_in = ST_WAIT_LUMA;
         end
         ST_WAIT_LUMA: begin
            if (div_done) begin
               // zero luma area reads as a mean of zero
               luma_mean_in = (luma_area == '0) ? '0 : div_quotient;
               state_in     = ST_START_CHROMA;
            end
         end
         ST_START_CHROMA: begin
            state_in = ST_WAIT_CHROMA;
         end
         ST_WAIT_CHROMA: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               status_in     = STATUS_OK;
               hash_in       = stats.hash;
               min_in        = stats.min_byte;
               max_in        = stats.max_byte;
               nonzero_in    = stats.nonzero;
               rsp_luma_in   = luma_mean_ff;
               rsp_chroma_in = div_quotient;
               state_in      = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      luma_mean_ff  <= luma_mean_in;
      status_ff     <= status_in;
      hash_ff       <= hash_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      nonzero_ff    <= nonzero_in;
      rsp_luma_ff   <= rsp_luma_in;
      rsp_chroma_ff <= rsp_chroma_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_frame_hash       = hash_ff;
   assign rsp_min_byte         = min_ff;
   assign rsp_max_byte         = max_ff;
   assign rsp_nonzero_count    = nonzero_ff;
   assign rsp_luma_mean_x100   = rsp_luma_ff;
   assign rsp_chroma_mean_x100 = rsp_chroma_ff;

   ready_low_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACCEPT) |-> !req_ready)
      else $error("input taken while the divider sequence runs");

   last_byte_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (step && last_byte) |=> (state_ff == ST_START_LUMA))
      else $error("frame end did not start the luma division");

   divider_idle_when_accepting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCEPT) |-> !div_busy)
      else $error("divider busy outside the divide sequence");

   invalid_word_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_BAD_GEOMETRY) |->
         (hash_ff == '0 && nonzero_ff == '0))
      else $error("invalid status word carries statistics");

endmodule

@@ rtl/fbs_accum.sv @@
// per-byte accumulators: fnv-1a hash, min, max, nonzero count, luma and chroma sums
module fbs_accum
   import fbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 step,
   input  logic [7:0]           pixel_byte,
   input  logic [AreaWidth-1:0] luma_area,
   output fbs_stats_type        stats
);

   fbs_stats_type stats_ff;
   fbs_stats_type stats_in;
   logic          is_luma;

   assign is_luma = AreaWidth'(stats_ff.byte_index) < luma_area;

   always_comb begin
      stats_in = stats_ff;
      if (clear) begin
         stats_in.hash       = FnvBasis;
         stats_in.min_byte   = MinReset;
         stats_in.max_byte   = '0;
         stats_in.nonzero    = '0;
         stats_in.luma_sum   = '0;
         stats_in.chroma_sum = '0;
         stats_in.byte_index = '0;
      end else if (step) begin
         stats_in.hash = (stats_ff.hash ^ {24'd0, pixel_byte}) * FnvPrime;
         if (pixel_byte != 8'd0) begin
            stats_in.nonzero = stats_ff.nonzero + 1'b1;
         end
         if (pixel_byte < stats_ff.min_byte) begin
            stats_in.min_byte = pixel_byte;
         end
         if (pixel_byte > stats_ff.max_byte) begin
            stats_in.max_byte = pixel_byte;
         end
         if (is_luma) begin
            stats_in.luma_sum = stats_ff.luma_sum + SumWidth'(pixel_byte);
         end else begin
            stats_in.chroma_sum = stats_ff.chroma_sum + SumWidth'(pixel_byte);
         end
         stats_in.byte_index = stats_ff.byte_index + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff.hash       <= FnvBasis;
         stats_ff.min_byte   <= MinReset;
         stats_ff.max_byte   <= '0;
         stats_ff.nonzero    <= '0;
         stats_ff.luma_sum   <= '0;
         stats_ff.chroma_sum <= '0;
         stats_ff.byte_index <= '0;
      end else begin
         stats_ff <= stats_in;
      end
   end

   assign stats = stats_ff;

endmodule

@@ rtl/fbs_divider.sv @@
// restoring divider, one quotient bit per cycle, keeps the low quotient bits
module fbs_divider
   import fbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DividendWidth-1:0] dividend,
   input  logic [AreaWidth-1:0]     divisor,
   output logic                     busy,
   output logic                     done,
   output logic [MeanWidth-1:0]     quotient
);

   logic                     busy_ff,  busy_in;
   logic                     done_ff,  done_in;
   logic [DivCountWidth-1:0] count_ff, count_in;
   logic [DividendWidth-1:0] num_ff,   num_in;
   logic [AreaWidth-1:0]     div_ff,   div_in;
   logic [AreaWidth-1:0]     rem_ff,   rem_in;
   logic [MeanWidth-1:0]     quo_ff,   quo_in;
   logic [AreaWidth:0]       trial;
   logic [AreaWidth:0]       diff;
   logic                     fits;

   assign trial = {rem_ff, num_ff[DividendWidth-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
         quo_in   = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits of the difference suffice
         rem_in   = fits ? diff[AreaWidth-1:0] : trial[AreaWidth-1:0];
         quo_in   = {quo_ff[MeanWidth-2:0], fits};
         num_in   = num_ff << 1;
         count_in = count_ff + 1'b1;
         if (count_ff == DivCountWidth'(DividendWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   start_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider flagged done while still busy");

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff < DivCountWidth'(DividendWidth)))
      else $error("divider step count out of range");

endmodule

@@ dv/frame_byte_statistics_tb.sv @@
// self-checking testbench for frame_byte_statistics with its own statistics predictor
module frame_byte_statistics_tb
   import fbs_pkg::*;
();

   localparam int unsigned ClockHigh   = 6;
   localparam int unsigned ClockLow    = 6;
   localparam int unsigned SettleTicks = 120;
   localparam int unsigned CycleLimit  = 600000;
   localparam int unsigned RandomWords = 800;
   localparam int unsigned ShownErrors = 10;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd3;
   localparam logic [SizeWidth-1:0] SizeAllOnes = '1;

   typedef enum {FILL_EXTREMES, FILL_LOW, FILL_ANY} fill_kind_type;

   typedef struct {
      logic                 status;
      logic [31:0]          hash;
      logic [7:0]           min_byte;
      logic [7:0]           max_byte;
      logic [SizeWidth-1:0] nonzero;
      logic [MeanWidth-1:0] luma_mean;
      logic [MeanWidth-1:0] chroma_mean;
   } frame_summary_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [7:0]               req_pixel_byte;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_status;
   logic [31:0]              rsp_frame_hash;
   logic [7:0]               rsp_min_byte;
   logic [7:0]               rsp_max_byte;
   logic [SizeWidth-1:0]     rsp_nonzero_count;
   logic [MeanWidth-1:0]     rsp_luma_mean_x100;
   logic [MeanWidth-1:0]     rsp_chroma_mean_x100;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [SizeWidth-1:0]     csr_write_data;

   // predictor copy of the registers and the running frame statistics
   logic [DimWidth-1:0]  width_reg;
   logic [DimWidth-1:0]  height_reg;
   logic [SizeWidth-1:0] size_reg;
   logic [31:0]          hash_acc;
   logic [7:0]           low_acc;
   logic [7:0]           high_acc;
   logic [SizeWidth-1:0] nonzero_acc;
   logic [SizeWidth-1:0] index_acc;
   logic [SumWidth-1:0]  luma_acc;
   logic [SumWidth-1:0]  chroma_acc;

   frame_summary_type summary_queue[$];

   bit          no_idle;
   int unsigned words_sent;
   int unsigned summaries_seen;
   int unsigned csr_writes;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   frame_byte_statistics uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_pixel_byte       (req_pixel_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_frame_hash       (rsp_frame_hash),
      .rsp_min_byte         (rsp_min_byte),
      .rsp_max_byte         (rsp_max_byte),
      .rsp_nonzero_count    (rsp_nonzero_count),
      .rsp_luma_mean_x100   (rsp_luma_mean_x100),
      .rsp_chroma_mean_x100 (rsp_chroma_mean_x100),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #ClockLow clock = 1'b1;
      #ClockHigh clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d summaries still pending",
                  cycle_count, summary_queue.size());
         $display("frame_byte_statistics_tb: done, errors");
         $finish;
      end
   end

   task automatic clear_frame_stats();
      hash_acc    = FnvBasis;
      low_acc     = MinReset;
      high_acc    = 8'd0;
      nonzero_acc = '0;
      index_acc   = '0;
      luma_acc    = '0;
      chroma_acc  = '0;
   endtask

   // folds one accepted word into the running frame and queues any summary it yields
   task automatic fold_pixel(input logic [7:0] value);
      logic [AreaWidth-1:0] area;
      logic [63:0]          luma_x100;
      logic [63:0]          chroma_x100;
      frame_summary_type    s;
      area = width_reg * height_reg;
      s = '{default: '0};
      if (size_reg == '0 || area >= size_reg) begin
         s.status = STATUS_BAD_GEOMETRY;
         summary_queue.push_back(s);
         return;
      end
      hash_acc = (hash_acc ^ {24'd0, value}) * FnvPrime;
      if (value != 8'd0) nonzero_acc++;
      if (value < low_acc) low_acc = value;
      if (value > high_acc) high_acc = value;
      if (index_acc < area) luma_acc += value;
      else chroma_acc += value;
      index_acc++;
      if (index_acc < size_reg) return;
      luma_x100   = (area == '0) ? 64'd0 : (64'(luma_acc) * 100) / area;
      chroma_x100 = (64'(chroma_acc) * 100) / (size_reg - area);
      s.status      = STATUS_OK;
      s.hash        = hash_acc;
      s.min_byte    = low_acc;
      s.max_byte    = high_acc;
      s.nonzero     = nonzero_acc;
      s.luma_mean   = MeanWidth'(luma_x100);
      s.chroma_mean = MeanWidth'(chroma_x100);
      summary_queue.push_back(s);
      clear_frame_stats();
   endtask

   function automatic void report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= ShownErrors) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   always @(posedge clock) begin
      frame_summary_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         summaries_seen++;
         if (summary_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected word st=%0d hash=%08h", rsp_status,
                                      rsp_frame_hash));
         end else begin
            want = summary_queue.pop_front();
            if (rsp_status !== want.status || rsp_frame_hash !== want.hash ||
                rsp_min_byte !== want.min_byte || rsp_max_byte !== want.max_byte ||
                rsp_nonzero_count !== want.nonzero ||
                rsp_luma_mean_x100 !== want.luma_mean ||
                rsp_chroma_mean_x100 !== want.chroma_mean) begin
               report_mismatch({$sformatf("expected st=%0d hash=%08h min=%0d max=%0d nz=%0d",
                                          want.status, want.hash, want.min_byte,
                                          want.max_byte, want.nonzero),
                                $sformatf(" luma=%0d chroma=%0d,", want.luma_mean,
                                          want.chroma_mean),
                                $sformatf(" got st=%0d hash=%08h min=%0d max=%0d nz=%0d",
                                          rsp_status, rsp_frame_hash, rsp_min_byte,
                                          rsp_max_byte, rsp_nonzero_count),
                                $sformatf(" luma=%0d chroma=%0d", rsp_luma_mean_x100,
                                          rsp_chroma_mean_x100)});
            end
         end
      end
   end

   // call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_pixel(input logic [7:0] value);
      if (!no_idle) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_pixel_byte <= value;
      do @(posedge clock); while (!req_ready);
      fold_pixel(value);
      words_sent++;
      @(negedge clock);
   endtask

   // stop sending, let every summary arrive, then cover the divider latency
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (summary_queue.size() != 0) @(negedge clock);
      repeat (SettleTicks) @(negedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [SizeWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      csr_writes++;
      case (idx)
         CSR_FRAME_WIDTH:  width_reg  = value[DimWidth-1:0];
         CSR_FRAME_HEIGHT: height_reg = value[DimWidth-1:0];
         CSR_FRAME_BYTES:  size_reg   = value;
         default:          ;
      endcase
      if (idx != CSR_SPARE) clear_frame_stats();
   endtask

   task automatic set_geometry(input logic [SizeWidth-1:0] w, input logic [SizeWidth-1:0] h,
                               input logic [SizeWidth-1:0] total);
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, h);
      write_register(CSR_FRAME_BYTES, total);
   endtask

   function automatic logic [7:0] pick_pixel(input fill_kind_type fill);
      case (fill)
         FILL_EXTREMES: return ($urandom_range(1) != 0) ? 8'hff : 8'h00;
         FILL_LOW:      return 8'($urandom_range(3));
         default:       return 8'($urandom);
      endcase
   endfunction

   // registers come up zero, so every word is rejected
   task automatic test_reset_geometry();
      send_pixel(8'h00);
      send_pixel(8'hff);
   endtask

   // one-word frames with no luma at all
   task automatic test_single_word_frames();
      wait_idle();
      set_geometry(0, 5, 1);
      send_pixel(8'h00);
      send_pixel(8'hff);
      send_pixel(8'ha5);
   endtask

   // width written with junk above bit 13; full luma and empty chroma
   task automatic test_small_frame();
      wait_idle();
      set_geometry(27'h7ffc002, 2, 5);
      repeat (4) send_pixel(8'hff);
      send_pixel(8'h00);
   endtask

   task automatic test_zero_height();
      wait_idle();
      set_geometry(8192, 0, 2);
      send_pixel(8'h01);
      send_pixel(8'hfe);
   endtask

   task automatic test_bad_geometry();
      wait_idle();
      set_geometry(1, 3, 3);
      send_pixel(8'h3c);
      wait_idle();
      // product only fits below the frame size if it were cut to 27 bits
      set_geometry(16383, 16383, SizeAllOnes);
      send_pixel(8'h5a);
   endtask

   task automatic test_frame_restart();
      wait_idle();
      set_geometry(1, 1, 3);
      send_pixel(8'h10);
      send_pixel(8'h20);
      wait_idle();
      write_register(CSR_SPARE, SizeAllOnes);
      send_pixel(8'h30);
      send_pixel(8'h40);
      wait_idle();
      write_register(CSR_FRAME_BYTES, 3);
      send_pixel(8'h50);
      send_pixel(8'h60);
      send_pixel(8'h70);
   endtask

   // a large valid geometry: only the first word, the next settings restart it
   task automatic test_huge_frame_start();
      wait_idle();
      set_geometry(8192, 8192, SizeAllOnes);
      send_pixel(8'hc3);
   endtask

   task automatic test_random_frames();
      int unsigned          first_word;
      int unsigned          phase;
      int unsigned          frames;
      logic [SizeWidth-1:0] w;
      logic [SizeWidth-1:0] h;
      logic [SizeWidth-1:0] area;
      logic [SizeWidth-1:0] total;
      fill_kind_type        fill;
      bit                   bad;
      first_word = words_sent;
      phase = 0;
      while (words_sent - first_word < RandomWords) begin
         wait_idle();
         no_idle = (phase >= 4 && phase < 9);
         bad = ($urandom_range(9) == 0);
         if ($urandom_range(7) == 0) begin
            w = SizeWidth'($urandom_range(20));
            h = SizeWidth'($urandom_range(20));
         end else begin
            w = SizeWidth'($urandom_range(6));
            h = SizeWidth'($urandom_range(6));
         end
         area = w * h;
         if (bad) total = SizeWidth'($urandom_range(area));
         else total = area + SizeWidth'($urandom_range(1, 16));
         set_geometry(SizeWidth'(($urandom << DimWidth) | w),
                      SizeWidth'(($urandom << DimWidth) | h), total);
         if ($urandom_range(3) == 0) write_register(CSR_SPARE, SizeWidth'($urandom));
         frames = bad ? 1 : $urandom_range(1, 4);
         repeat (frames) begin
            fill = fill_kind_type'($urandom_range(2));
            repeat (bad ? $urandom_range(1, 8) : total) send_pixel(pick_pixel(fill));
         end
         // sometimes leave a frame half done for the next settings to cut off
         if (!bad && total > 1 && $urandom_range(4) == 0) begin
            fill = fill_kind_type'($urandom_range(2));
            repeat ($urandom_range(1, total - 1)) send_pixel(pick_pixel(fill));
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_byte   = 8'd0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      no_idle          = 1'b0;
      width_reg        = '0;
      height_reg       = '0;
      size_reg         = '0;
      clear_frame_stats();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_single_word_frames();
      test_small_frame();
      test_zero_height();
      test_bad_geometry();
      test_frame_restart();
      test_huge_frame_start();
      test_random_frames();
      wait_idle();

      $display("sent %0d pixel words over %0d register writes, checked %0d summaries",
               words_sent, csr_writes, summaries_seen);
      $display("%0d mismatches, stalls on both channels plus one gap-free stretch",
               mismatch_count);
      if (mismatch_count == 0 && summary_queue.size() == 0) begin
         $display("frame_byte_statistics_tb: done, clean");
      end else begin
         $display("frame_byte_statistics_tb: done, errors");
      end
      $finish;
   end

endmodule
